FILE: hw/rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// Holds the item structs, controller command struct and register map.
// No dependencies.
`default_nettype none

package lrupr_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int PAGE_BITS_DEF = 16;

  localparam int PAGE_FIELD_W = 16;
  localparam int SLOT_FIELD_W = 4;
  localparam int FAULT_W      = 16;
  localparam int FRAMES_W     = 5;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [PADDR_W-3:0] REG_FRAMES_IN_USE = '0;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET     = 5'd4;
  localparam logic [FAULT_W-1:0]  FAULT_MAX        = '1;

  typedef struct packed {
    logic [PAGE_FIELD_W-1:0] page_number;
    logic                    restart;
    logic                    last_ref;
  } ref_item_t;

  typedef struct packed {
    logic                    hit;
    logic [SLOT_FIELD_W-1:0] frame_slot;
    logic                    evicted_valid;
    logic [PAGE_FIELD_W-1:0] evicted_page;
    logic [FAULT_W-1:0]      fault_total;
    logic                    run_done;
  } res_item_t;

  typedef struct packed {
    logic latch;   // input transfer: capture the reference
    logic decide;  // search frames and register the decision
    logic update;  // apply the decision and load the result register
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lru_page_replacement.sv
// LRU page replacement engine, top level.
// Reference channel (ref_valid/ref_ready/ref_item) takes one page reference per
// transfer; result channel (res_valid/res_ready/res_item) returns one result each.
// APB-style port at byte address 0 holds frames_in_use (reset 4; 0 acts as 1,
// values above MAX_SLOTS act as MAX_SLOTS). Write it only while the block is idle.
// Timing: a reference is searched in the cycle after its transfer (compare state),
// and the result register loads in the update state that follows, once the output
// is free. The next reference is taken in the same cycle the result loads, so each
// reference passes through the search state and then the rank-update state.
// A restart flag empties all frames and clears the fault count before its
// reference is handled. Reset (rst, synchronous) empties all frames, clears the
// fault count and restores frames_in_use to 4.
// When the receiver stalls, the finished result holds in the output register and
// one more reference is taken and searched; further transfers wait for the
// result register to free up.
// Depends on lrupr_pkg, lrupr_ctrl and lrupr_dp.
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_SLOTS = lrupr_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             ref_valid,
  output logic                                  ref_ready,
  input  wire lrupr_pkg::ref_item_t             ref_item,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output lrupr_pkg::res_item_t                  res_item,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [lrupr_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [lrupr_pkg::PDATA_W-1:0]    pwdata,
  output logic      [lrupr_pkg::PDATA_W-1:0]    prdata,
  output logic                                  pready
);

  lrupr_pkg::cmd_t                cmd;
  logic [lrupr_pkg::FRAMES_W-1:0] frames_in_use;
  logic                           frames_sel;

  assign pready     = 1'b1;
  assign frames_sel = (paddr[lrupr_pkg::PADDR_W-1:2] == lrupr_pkg::REG_FRAMES_IN_USE);
  assign prdata     = frames_sel ? lrupr_pkg::PDATA_W'(frames_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupr_pkg::FRAMES_RESET;
    end else if (psel && penable && pwrite && pready && frames_sel) begin
      frames_in_use <= pwdata[lrupr_pkg::FRAMES_W-1:0];
    end
  end

  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .ref_valid (ref_valid),
    .ref_ready (ref_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd)
  );

  lrupr_dp #(
    .MAX_SLOTS (MAX_SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .frames_in_use (frames_in_use),
    .ref_item      (ref_item),
    .res_item      (res_item)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/lrupr_ctrl.sv
// Controller for the LRU page replacement block: sequences search and update.
// Drives lrupr_pkg::cmd_t to the datapath and owns both handshakes.
`default_nettype none

module lrupr_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         ref_valid,
  output logic              ref_ready,
  output logic              res_valid,
  input  wire logic         res_ready,
  output lrupr_pkg::cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free   = !res_valid || res_ready;
  assign ref_ready  = (state == ST_IDLE) || ((state == ST_UPD) && out_free);
  assign cmd.latch  = ref_valid && ref_ready;
  assign cmd.decide = (state == ST_CMP);
  assign cmd.update = (state == ST_UPD) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.latch) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_next = cmd.latch ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) res_valid <= 1'b1;
      else if (res_ready) res_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lrupr_dp.sv
// Datapath for the LRU page replacement block: frame table, ranks, fault count.
// Depends on lrupr_pkg; driven by lrupr_ctrl commands.
`default_nettype none

module lrupr_dp #(
  parameter int MAX_SLOTS = lrupr_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lrupr_pkg::cmd_t                   cmd,
  input  wire logic [lrupr_pkg::FRAMES_W-1:0]    frames_in_use,
  input  wire lrupr_pkg::ref_item_t              ref_item,
  output lrupr_pkg::res_item_t                   res_item
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PW     = (PAGE_BITS < lrupr_pkg::PAGE_FIELD_W) ? PAGE_BITS
                                                                 : lrupr_pkg::PAGE_FIELD_W;
  localparam int CMP_W  = (SLOT_W + 1 > lrupr_pkg::FRAMES_W) ? SLOT_W + 1
                                                              : lrupr_pkg::FRAMES_W;
  localparam logic [SLOT_W-1:0] RANK_MAX = '1;

  logic [PW-1:0]      resident [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] valid;
  logic [SLOT_W-1:0]  rank [MAX_SLOTS];
  logic [SLOT_W-1:0]  rank_upd [MAX_SLOTS];
  logic [lrupr_pkg::FAULT_W-1:0] faults;
  logic [lrupr_pkg::FAULT_W-1:0] fault_upd;

  logic [PW-1:0]      page_q;
  logic               last_q;

  logic               dec_hit;
  logic               dec_empty;
  logic [SLOT_W-1:0]  dec_slot;
  logic [SLOT_W-1:0]  dec_old;
  logic [PW-1:0]      dec_ev_page;

  logic [MAX_SLOTS-1:0] active;
  logic [MAX_SLOTS-1:0] match;
  logic [MAX_SLOTS-1:0] empty;
  logic [MAX_SLOTS-1:0] oldest;
  logic [SLOT_W-1:0]    hit_slot;
  logic [SLOT_W-1:0]    empty_slot;
  logic [SLOT_W-1:0]    old_slot;
  logic [SLOT_W-1:0]    sel_slot;
  logic [CMP_W-1:0]     frames_ext;

  function automatic logic [SLOT_W-1:0] enc_low(input logic [MAX_SLOTS-1:0] v);
    logic [MAX_SLOTS-1:0] low;
    logic [SLOT_W-1:0]    idx;
    low = v & (~v + MAX_SLOTS'(1));
    idx = '0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (low[i]) idx = idx | SLOT_W'(i);
    end
    return idx;
  endfunction

  assign frames_ext = CMP_W'(frames_in_use);

  // frame 0 is always managed; a count of zero acts as one
  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      active[j] = (j == 0) || (CMP_W'(j) < frames_ext);
      match[j]  = active[j] && valid[j] && (resident[j] == page_q);
      empty[j]  = active[j] && !valid[j];
    end
  end

  // oldest: strictly older than every lower frame, at least as old as every higher one
  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      oldest[j] = active[j];
      for (int k = 0; k < MAX_SLOTS; k++) begin
        if (active[k] && (k < j) && !(rank[j] > rank[k])) oldest[j] = 1'b0;
        if (active[k] && (k > j) && (rank[j] < rank[k])) oldest[j] = 1'b0;
      end
    end
  end

  assign hit_slot   = enc_low(match);
  assign empty_slot = enc_low(empty);
  assign old_slot   = enc_low(oldest);

  always_comb begin
    if (|match) sel_slot = hit_slot;
    else if (|empty) sel_slot = empty_slot;
    else sel_slot = old_slot;
  end

  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      rank_upd[j] = rank[j];
      if (SLOT_W'(j) == dec_slot) begin
        rank_upd[j] = '0;
      end else if (active[j] && valid[j] && (dec_empty || (rank[j] < dec_old)) &&
                   (rank[j] != RANK_MAX)) begin
        rank_upd[j] = rank[j] + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    fault_upd = faults;
    if (!dec_hit && (faults != lrupr_pkg::FAULT_MAX)) fault_upd = faults + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      faults <= '0;
      for (int j = 0; j < MAX_SLOTS; j++) rank[j] <= '0;
    end else if (cmd.latch && ref_item.restart) begin
      valid  <= '0;
      faults <= '0;
      for (int j = 0; j < MAX_SLOTS; j++) rank[j] <= '0;
    end else if (cmd.update) begin
      faults          <= fault_upd;
      valid[dec_slot] <= 1'b1;
      for (int j = 0; j < MAX_SLOTS; j++) rank[j] <= rank_upd[j];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && !dec_hit) resident[dec_slot] <= page_q;
    if (cmd.latch) begin
      page_q <= ref_item.page_number[PW-1:0];
      last_q <= ref_item.last_ref;
    end
    if (cmd.decide) begin
      dec_hit     <= |match;
      dec_empty   <= !(|match) && (|empty);
      dec_slot    <= sel_slot;
      dec_old     <= rank[sel_slot];
      dec_ev_page <= resident[sel_slot];
    end
    if (cmd.update) begin
      res_item.hit           <= dec_hit;
      res_item.frame_slot    <= lrupr_pkg::SLOT_FIELD_W'(dec_slot);
      res_item.evicted_valid <= !dec_hit && !dec_empty;
      res_item.evicted_page  <= (!dec_hit && !dec_empty) ?
                                lrupr_pkg::PAGE_FIELD_W'(dec_ev_page) : '0;
      res_item.fault_total   <= fault_upd;
      res_item.run_done      <= last_q;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb_lru_page_replacement.sv
// Testbench for lru_page_replacement: reference stream in, one result per transfer out.
// A scoreboard class predicts each result from its own LRU frame table and checks in order.
// Depends on lrupr_pkg and the lru_page_replacement RTL.

class lru_scoreboard;
  logic [15:0] frame_page[16];
  bit          frame_used[16];
  logic [7:0]  frame_age[16];
  logic [15:0] faults;
  logic [4:0]  frames_cfg;
  lrupr_pkg::res_item_t expected_q[$];
  int mismatches;

  function new();
    for (int j = 0; j < 16; j++) begin
      frame_page[j] = '0;
      frame_used[j] = 0;
      frame_age[j]  = '0;
    end
    faults     = '0;
    frames_cfg = lrupr_pkg::FRAMES_RESET;
    mismatches = 0;
  endfunction

  function int slots_now();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > 16) return 16;
    return int'(frames_cfg);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void flag(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  // make frame s most recent; younger valid frames (all when s was empty) age by one
  function void age_frames(int n, int s, bit was_empty);
    logic [7:0] old_age;
    old_age = frame_age[s];
    for (int j = 0; j < n; j++) begin
      if (j != s && frame_used[j] && (was_empty || frame_age[j] < old_age) &&
          frame_age[j] != 8'hFF) begin
        frame_age[j]++;
      end
    end
    frame_age[s] = '0;
  endfunction

  function void note_ref(lrupr_pkg::ref_item_t it);
    lrupr_pkg::res_item_t r;
    int n;
    int s;
    bit found;
    bit empty_found;
    r = '0;
    n = slots_now();
    s = 0;
    found = 0;
    empty_found = 0;
    if (it.restart) begin
      for (int j = 0; j < 16; j++) begin
        frame_used[j] = 0;
        frame_age[j]  = '0;
      end
      faults = '0;
    end
    for (int j = 0; j < n; j++) begin
      if (!found && frame_used[j] && frame_page[j] == it.page_number) begin
        s = j;
        found = 1;
      end
    end
    if (found) begin
      age_frames(n, s, 0);
    end else begin
      for (int j = 0; j < n; j++) begin
        if (!empty_found && !frame_used[j]) begin
          s = j;
          empty_found = 1;
        end
      end
      if (empty_found) begin
        age_frames(n, s, 1);
      end else begin
        s = 0;
        for (int j = 1; j < n; j++) begin
          if (frame_age[j] > frame_age[s]) s = j;
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = frame_page[s];
        age_frames(n, s, 0);
      end
      frame_page[s] = it.page_number;
      frame_used[s] = 1;
      if (faults != lrupr_pkg::FAULT_MAX) faults++;
    end
    r.hit         = found;
    r.frame_slot  = 4'(s);
    r.fault_total = faults;
    r.run_done    = it.last_ref;
    expected_q.push_back(r);
  endfunction

  function void check_result(lrupr_pkg::res_item_t got);
    lrupr_pkg::res_item_t want;
    if (expected_q.size() == 0) begin
      flag($sformatf("result with nothing outstanding: %h", got));
      return;
    end
    want = expected_q.pop_front();
    if (got.hit !== want.hit || got.frame_slot !== want.frame_slot ||
        got.evicted_valid !== want.evicted_valid || got.evicted_page !== want.evicted_page ||
        got.fault_total !== want.fault_total || got.run_done !== want.run_done) begin
      flag($sformatf({"exp hit=%0d slot=%0d ev=%0d ev_page=%h faults=%0d done=%0d; ",
                      "got hit=%0d slot=%0d ev=%0d ev_page=%h faults=%0d done=%0d"},
                     want.hit, want.frame_slot, want.evicted_valid, want.evicted_page,
                     want.fault_total, want.run_done,
                     got.hit, got.frame_slot, got.evicted_valid, got.evicted_page,
                     got.fault_total, got.run_done));
    end
  endfunction
endclass

module tb_lru_page_replacement;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [lrupr_pkg::PADDR_W-1:0] FRAMES_ADDR =
    {lrupr_pkg::REG_FRAMES_IN_USE, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ref_valid = 1'b0;
  logic ref_ready;
  lrupr_pkg::ref_item_t ref_item = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  lrupr_pkg::res_item_t res_item;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lrupr_pkg::PADDR_W-1:0] paddr = '0;
  logic [lrupr_pkg::PDATA_W-1:0] pwdata = '0;
  logic [lrupr_pkg::PDATA_W-1:0] prdata;
  logic pready;

  lru_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 0;
  bit hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  lru_page_replacement i_dut (
    .clk(clk), .rst(rst),
    .ref_valid(ref_valid), .ref_ready(ref_ready), .ref_item(ref_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (ref_valid && ref_ready) sb.note_ref(ref_item);
      if (res_valid && res_ready) sb.check_result(res_item);
    end
  end

  function automatic lrupr_pkg::ref_item_t mk(logic [15:0] page, logic restart, logic last);
    lrupr_pkg::ref_item_t it;
    it.page_number = page;
    it.restart     = restart;
    it.last_ref    = last;
    return it;
  endfunction

  task automatic send_ref(input lrupr_pkg::ref_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      ref_valid <= 1'b0;
      @(posedge clk);
    end
    ref_valid <= 1'b1;
    ref_item  <= it;
    do @(posedge clk); while (!ref_ready);
  endtask

  task automatic wait_idle();
    ref_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [lrupr_pkg::PDATA_W-1:0] wdata,
                            input logic [lrupr_pkg::PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FRAMES_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata !== want)
      sb.flag($sformatf("frames_in_use read exp %h got %h", want, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frames(input logic [4:0] v);
    reg_access(1'b1, {27'b0, v}, '0);
    sb.frames_cfg = v;
    reg_access(1'b0, '0, {27'b0, v});
  endtask

  task automatic run_random(input int count, input int hold_at);
    logic [15:0] base;
    logic [15:0] page;
    base = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        wait_idle();
        case ($urandom_range(0, 6))
          0: set_frames(5'd0);
          1: set_frames(5'd1);
          2: set_frames(5'd16);
          3: set_frames(5'd17);
          4: set_frames(5'd31);
          default: set_frames(5'($urandom_range(0, 31)));
        endcase
        base = 16'($urandom);
      end
      if (i == hold_at) hold_req = 1;
      if ($urandom_range(99) < 10) page = 16'($urandom_range(0, 65535));
      else page = base ^ 16'($urandom_range(0, sb.slots_now() + 3));
      send_ref(mk(page, $urandom_range(99) < 4, $urandom_range(99) < 10));
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, '0, {27'b0, lrupr_pkg::FRAMES_RESET});

    tx_idle_pct = 15;
    rx_idle_pct = 47;
    // fill, hit, then evictions with four frames
    send_ref(mk(16'h0000, 1, 0));
    send_ref(mk(16'hFFFF, 0, 0));
    send_ref(mk(16'h0000, 0, 0));
    send_ref(mk(16'h0005, 0, 0));
    send_ref(mk(16'h0006, 0, 0));
    send_ref(mk(16'h0007, 0, 0));
    send_ref(mk(16'h0000, 0, 0));
    send_ref(mk(16'h0008, 0, 0));
    send_ref(mk(16'h0006, 0, 1));
    // shrink mid-string: upper frames keep contents and duplicates appear
    wait_idle();
    set_frames(5'd2);
    send_ref(mk(16'h0006, 0, 0));
    send_ref(mk(16'h0000, 0, 0));
    send_ref(mk(16'h0008, 0, 0));
    // grow back: several matches and tied ages
    wait_idle();
    set_frames(5'd16);
    send_ref(mk(16'h0006, 0, 0));
    send_ref(mk(16'h0008, 0, 0));
    send_ref(mk(16'h0000, 0, 0));
    send_ref(mk(16'h0009, 0, 0));
    wait_idle();
    set_frames(5'd0);
    send_ref(mk(16'h0009, 0, 0));
    send_ref(mk(16'h000A, 0, 1));
    wait_idle();
    set_frames(5'd31);
    send_ref(mk(16'h000A, 0, 0));
    send_ref(mk(16'h0003, 1, 0));
    send_ref(mk(16'h0003, 0, 0));
    run_random(170, 60);

    wait_idle();
    tx_idle_pct = 47;
    rx_idle_pct = 15;
    run_random(170, -1);

    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(160, -1);

    // one frame, alternating pages: every reference misses; all but the restart ones evict
    wait_idle();
    set_frames(5'd1);
    send_ref(mk(16'h1234, 1, 0));
    for (int i = 0; i < 10; i++)
      send_ref(mk(((i % 2) != 0) ? 16'h1234 : 16'hEDCB, 0, $urandom_range(99) < 20));
    send_ref(mk(16'h1234, 1, 1));

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
